@@ hdl/kda_pkg.sv @@
package kda_pkg;

  localparam logic [7:0] NO_KEY     = 8'hFF;
  localparam logic [7:0] CODE_FORCE = 8'hC0;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS      = 2'd0,
    REG_REPEAT_WAIT_TICKS   = 2'd1,
    REG_REPEAT_PERIOD_TICKS = 2'd2,
    REG_UNUSED              = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SCAN  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] repeat_wait_ticks;
    logic [7:0] repeat_period_ticks;
  } kda_cfg_t;

  typedef struct packed {
    logic [7:0] previous_sample;
    logic [7:0] stable_count;
    logic [7:0] accepted_key;
    logic [7:0] last_accepted;
    logic [7:0] pending_key;
    logic [7:0] release_code;
    logic [7:0] wait_count;
    logic [7:0] period_count;
  } kda_state_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

@@ hdl/kda_if.sv @@
interface kda_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] row_sample;
  logic [7:0] column_sample;

  modport source (output valid, output cmd, output row_sample, output column_sample,
                  input ready);
  modport sink (input valid, input cmd, input row_sample, input column_sample,
                output ready);
endinterface

interface kda_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] fetched_key;
  logic [7:0] released_key;
  logic [7:0] debounced_key;

  modport source (output valid, output fetched_key, output released_key,
                  output debounced_key, input ready);
  modport sink (input valid, input fetched_key, input released_key,
                input debounced_key, output ready);
endinterface

interface kda_cfg_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/keypad_debounce_autorepeat_unit.sv @@
// a result is registered and shows in the cycle after its item is accepted
// throughput: one item per cycle; the single output register refills in the
// cycle it is taken, so input ready is low only while a result waits unread
// reset (rst_n low, synchronous): output empty, scan state and pending key
// cleared, registers back to debounce 5, repeat wait 50, repeat period 10
module keypad_debounce_autorepeat_unit import kda_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  kda_in_if.sink    in_chan,
  kda_out_if.source out_chan,
  kda_cfg_if.sink   cfg_chan
);

  // configuration registers, always writable
  kda_cfg_t cfg_r;

  // result register
  logic       out_valid_r;
  logic [7:0] fetched_r;
  logic [7:0] released_r;
  logic [7:0] debounced_r;

  logic       in_accept;
  logic [7:0] fetched_nxt;
  logic [7:0] released_nxt;
  logic [7:0] debounced_nxt;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks      <= 8'd5;
      cfg_r.repeat_wait_ticks   <= 8'd50;
      cfg_r.repeat_period_ticks <= 8'd10;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_DEBOUNCE_TICKS:      cfg_r.debounce_ticks      <= cfg_chan.data;
        REG_REPEAT_WAIT_TICKS:   cfg_r.repeat_wait_ticks   <= cfg_chan.data;
        REG_REPEAT_PERIOD_TICKS: cfg_r.repeat_period_ticks <= cfg_chan.data;
        default: begin
          // writes to unmapped indexes are dropped
        end
      endcase
    end
  end

  // take a new item whenever the result slot is free or being emptied
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // all key state lives in the scan core and moves only on an accepted item
  kda_scan_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_accept),
    .cmd           (in_chan.cmd),
    .row_sample    (in_chan.row_sample),
    .column_sample (in_chan.column_sample),
    .cfg           (cfg_r),
    .fetched_key   (fetched_nxt),
    .released_key  (released_nxt),
    .debounced_key (debounced_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads only with a new item, so a stalled result holds
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fetched_r   <= fetched_nxt;
      released_r  <= released_nxt;
      debounced_r <= debounced_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.fetched_key   = fetched_r;
  assign out_chan.released_key  = released_r;
  assign out_chan.debounced_key = debounced_r;

endmodule

@@ hdl/kda_scan_core.sv @@
module kda_scan_core import kda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       cmd,
  input  logic [7:0] row_sample,
  input  logic [7:0] column_sample,
  input  kda_cfg_t   cfg,
  output logic [7:0] fetched_key,
  output logic [7:0] released_key,
  output logic [7:0] debounced_key
);

  kda_state_t st_r, st_nxt;
  logic [7:0] code;
  logic       wait_done;
  logic       period_done;

  assign code = row_sample | column_sample | CODE_FORCE;

  always_comb begin
    st_nxt      = st_r;
    fetched_key = NO_KEY;
    wait_done   = st_r.wait_count >= cfg.repeat_wait_ticks;
    period_done = st_r.period_count >= cfg.repeat_period_ticks;
    if (cmd == CMD_FETCH) begin
      fetched_key        = st_r.pending_key;
      st_nxt.pending_key = NO_KEY;
    end else if (code != st_r.previous_sample) begin
      // new code restarts debounce and repeat timing
      st_nxt.pending_key     = NO_KEY;
      st_nxt.stable_count    = 8'd0;
      st_nxt.previous_sample = code;
      st_nxt.period_count    = 8'd0;
      st_nxt.wait_count      = 8'd0;
    end else if (st_r.stable_count < cfg.debounce_ticks) begin
      st_nxt.stable_count = st_r.stable_count + 8'd1;
    end else begin
      st_nxt.accepted_key = code;
      if (st_r.last_accepted == code) begin
        st_nxt.wait_count = sat_inc(st_r.wait_count);
        if (wait_done) begin
          if (period_done) begin
            st_nxt.pending_key  = code;
            st_nxt.period_count = 8'd0;
          end else begin
            st_nxt.pending_key  = NO_KEY;
            st_nxt.period_count = sat_inc(st_r.period_count);
          end
        end
      end else begin
        st_nxt.pending_key  = code;
        st_nxt.period_count = 8'd0;
        st_nxt.wait_count   = 8'd0;
      end
      if (code == NO_KEY) begin
        st_nxt.release_code = st_r.last_accepted;
      end
      st_nxt.last_accepted = code;
    end
    released_key  = st_nxt.release_code;
    debounced_key = st_nxt.accepted_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.previous_sample <= 8'd0;
      st_r.stable_count    <= 8'd0;
      st_r.accepted_key    <= 8'd0;
      st_r.last_accepted   <= NO_KEY;
      st_r.pending_key     <= NO_KEY;
      st_r.release_code    <= 8'd0;
      st_r.wait_count      <= 8'd0;
      st_r.period_count    <= 8'd0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ hdl/kda_checker.sv @@
module kda_checker import kda_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_fetched_key,
  input logic [7:0] out_released_key,
  input logic [7:0] out_debounced_key
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // output slot is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // every accepted item gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted item gave no result");

  // a scan tick never reports a fetched key
  a_scan_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_SCAN) |=> (out_fetched_key == NO_KEY))
    else $error("scan tick reported a fetched key");

  // a fetch straight after a fetch finds the pending key cleared
  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_FETCH) ##1 (in_acc && in_cmd == CMD_FETCH)
      |=> (out_fetched_key == NO_KEY))
    else $error("pending key not cleared by fetch");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_fetched_key) && $stable(out_released_key)
       && $stable(out_debounced_key)))
    else $error("stalled result changed");

endmodule

bind keypad_debounce_autorepeat_unit kda_checker u_kda_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_cmd            (in_chan.cmd),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_fetched_key   (out_chan.fetched_key),
  .out_released_key  (out_chan.released_key),
  .out_debounced_key (out_chan.debounced_key)
);
